>>> rtl/kalman_tilt_estimator_defines.svh
// ----------------------------------------------------------------------------
// Kalman tilt estimator assertion macros
// Shared assertion wrappers; they expand to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef KALMAN_TILT_ESTIMATOR_DEFINES_SVH
`define KALMAN_TILT_ESTIMATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define KTE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");
`define KTE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define KTE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define KTE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/kte_pkg.sv
// ----------------------------------------------------------------------------
// Kalman tilt estimator package
// Shared constants, types, codes and saturating arithmetic helpers.
// ----------------------------------------------------------------------------
package kte_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int CORDIC_STEPS    = 16;
  localparam int CORDIC_ITERS    = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
  localparam int MS_PER_S        = 1000;
  localparam int HALF_TURN_DEG   = 180;
  localparam int DATA_W          = 32;
  localparam int DIV_NUM_W       = DATA_W + FRAC_BITS + 1;
  localparam int DIV_CNT_W       = $clog2(DIV_NUM_W);
  localparam int MUL_CNT_W       = $clog2(DATA_W);
  localparam int CORDIC_W        = 34;
  localparam int CORDIC_PRESCALE = 14;
  localparam int ITER_W          = (CORDIC_ITERS > 1) ? $clog2(CORDIC_ITERS) : 1;
  localparam int ANG_FRAC        = 24;
  localparam int ZRND_SH         = ANG_FRAC - FRAC_BITS;
  localparam int GYRO_SHIFT      = FRAC_BITS - 4;

  typedef logic signed [DATA_W-1:0] q_t;

  localparam q_t Q_MAX = 32'sh7fff_ffff;
  localparam q_t Q_MIN = 32'sh8000_0000;

  typedef enum logic [2:0] {
    CFG_MIN_PERIOD    = 3'd0,
    CFG_ANGLE_NOISE   = 3'd1,
    CFG_BIAS_NOISE    = 3'd2,
    CFG_MEASURE_NOISE = 3'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    OP_DT, OP_ATAN, OP_M1, OP_M2, OP_M3, OP_M4, OP_D0, OP_D1,
    OP_M5, OP_M6, OP_M7, OP_M8, OP_M9, OP_M10
  } op_t;

  function automatic q_t sat32(input logic signed [63:0] v);
    q_t r;
    if (v > 64'(Q_MAX)) r = Q_MAX;
    else if (v < 64'(Q_MIN)) r = Q_MIN;
    else r = v[DATA_W-1:0];
    return r;
  endfunction

  function automatic q_t qadd(input q_t a, input q_t b);
    return sat32(64'(a) + 64'(b));
  endfunction

  function automatic q_t qsub(input q_t a, input q_t b);
    return sat32(64'(a) - 64'(b));
  endfunction

  function automatic logic [DATA_W-1:0] qabs(input q_t v);
    return v[DATA_W-1] ? (DATA_W'(0) - DATA_W'(v)) : DATA_W'(v);
  endfunction

  // Noise registers are in units of 2^-16; align them to the working format.
  function automatic q_t noise_to_q(input logic [15:0] v);
    logic [47:0] w;
    w = {32'd0, v};
    if (FRAC_BITS >= 16) w = w << (FRAC_BITS - 16);
    else w = w >> (16 - FRAC_BITS);
    return q_t'(w[DATA_W-1:0]);
  endfunction

  // Arctangent of 2^-i in degrees, Q.24.
  function automatic logic signed [CORDIC_W-1:0] atan_q24(input logic [4:0] i);
    logic signed [CORDIC_W-1:0] r;
    unique case (i)
      5'd0:    r = 34'sd754974720;
      5'd1:    r = 34'sd445687602;
      5'd2:    r = 34'sd235489088;
      5'd3:    r = 34'sd119537938;
      5'd4:    r = 34'sd60000934;
      5'd5:    r = 34'sd30029717;
      5'd6:    r = 34'sd15018523;
      5'd7:    r = 34'sd7509720;
      5'd8:    r = 34'sd3754917;
      5'd9:    r = 34'sd1877466;
      5'd10:   r = 34'sd938734;
      5'd11:   r = 34'sd469367;
      5'd12:   r = 34'sd234684;
      5'd13:   r = 34'sd117342;
      5'd14:   r = 34'sd58671;
      5'd15:   r = 34'sd29335;
      5'd16:   r = 34'sd14668;
      5'd17:   r = 34'sd7334;
      5'd18:   r = 34'sd3667;
      5'd19:   r = 34'sd1833;
      5'd20:   r = 34'sd917;
      5'd21:   r = 34'sd458;
      5'd22:   r = 34'sd229;
      5'd23:   r = 34'sd115;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/kte_mul.sv
// ----------------------------------------------------------------------------
// Serial fixed-point multiplier
// Shift-add over one multiplier bit per cycle, then round and saturate.
// ----------------------------------------------------------------------------
module kte_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  kte_pkg::q_t a,
  input  kte_pkg::q_t b,
  output logic        done,
  output kte_pkg::q_t result
);
  import kte_pkg::*;

  localparam logic signed [2*DATA_W-1:0] RND = 64'sd1 <<< (FRAC_BITS - 1);

  logic                        busy_r, busy_nxt, fin_r, fin_nxt, done_r, done_nxt;
  logic                        neg_r, neg_nxt;
  logic [MUL_CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [DATA_W-1:0]           mcand_r, mcand_nxt, hi_r, hi_nxt, lo_r, lo_nxt;
  q_t                          res_r, res_nxt;
  logic [DATA_W:0]             sum;
  logic signed [2*DATA_W-1:0]  prod;

  always_comb begin
    busy_nxt  = busy_r;
    fin_nxt   = fin_r;
    done_nxt  = 1'b0;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    mcand_nxt = mcand_r;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    res_nxt   = res_r;
    sum  = {1'b0, hi_r} + (lo_r[0] ? {1'b0, mcand_r} : '0);
    prod = neg_r ? -$signed({hi_r, lo_r}) : $signed({hi_r, lo_r});
    if (start) begin
      mcand_nxt = qabs(a);
      lo_nxt    = qabs(b);
      hi_nxt    = '0;
      neg_nxt   = a[DATA_W-1] ^ b[DATA_W-1];
      cnt_nxt   = '0;
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      hi_nxt  = sum[DATA_W:1];
      lo_nxt  = {sum[0], lo_r[DATA_W-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == MUL_CNT_W'(DATA_W - 1)) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end else if (fin_r) begin
      fin_nxt  = 1'b0;
      done_nxt = 1'b1;
      res_nxt  = sat32((prod + RND) >>> FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      done_r <= done_nxt;
    end
    neg_r   <= neg_nxt;
    cnt_r   <= cnt_nxt;
    mcand_r <= mcand_nxt;
    hi_r    <= hi_nxt;
    lo_r    <= lo_nxt;
    res_r   <= res_nxt;
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

>>> rtl/kte_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division, one quotient bit per cycle, signed saturated result.
// ----------------------------------------------------------------------------
module kte_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [kte_pkg::DIV_NUM_W-1:0]  num,
  input  logic [kte_pkg::DATA_W-1:0]     den,
  input  logic                           neg,
  output logic                           done,
  output kte_pkg::q_t                    result
);
  import kte_pkg::*;

  localparam logic [DIV_NUM_W-1:0] LIM_POS = DIV_NUM_W'(64'h7fff_ffff);
  localparam logic [DIV_NUM_W-1:0] LIM_NEG = DIV_NUM_W'(64'h8000_0000);

  logic                  busy_r, busy_nxt, fin_r, fin_nxt, done_r, done_nxt;
  logic                  neg_r, neg_nxt, zero_r, zero_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DATA_W-1:0]     rem_r, rem_nxt, den_r, den_nxt;
  logic [DIV_NUM_W-1:0]  quo_r, quo_nxt;
  q_t                    res_r, res_nxt;
  logic [DATA_W:0]       trial, diff;
  logic                  fits;

  always_comb begin
    busy_nxt = busy_r;
    fin_nxt  = fin_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    zero_nxt = zero_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    res_nxt  = res_r;
    trial = {rem_r, quo_r[DIV_NUM_W-1]};
    diff  = trial - {1'b0, den_r};
    fits  = (trial >= {1'b0, den_r});
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = num;
      den_nxt  = den;
      neg_nxt  = neg;
      zero_nxt = (den == '0);
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      quo_nxt = {quo_r[DIV_NUM_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_NUM_W - 1)) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end else if (fin_r) begin
      fin_nxt  = 1'b0;
      done_nxt = 1'b1;
      if (zero_r) res_nxt = '0;
      else if (neg_r) res_nxt = (quo_r > LIM_NEG) ? Q_MIN : q_t'(DATA_W'(0) - quo_r[DATA_W-1:0]);
      else res_nxt = (quo_r > LIM_POS) ? Q_MAX : q_t'(quo_r[DATA_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      done_r <= done_nxt;
    end
    neg_r  <= neg_nxt;
    zero_r <= zero_nxt;
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quo_r  <= quo_nxt;
    res_r  <= res_nxt;
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

>>> rtl/kte_cordic.sv
// ----------------------------------------------------------------------------
// CORDIC arctangent
// Vectoring-mode atan2 in degrees, one rotation per cycle.
// ----------------------------------------------------------------------------
module kte_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [16:0] y_in,
  input  logic signed [16:0] x_in,
  output logic               done,
  output kte_pkg::q_t        result
);
  import kte_pkg::*;

  localparam logic signed [CORDIC_W-1:0] Z_QUARTER =
    CORDIC_W'(HALF_TURN_DEG / 2) <<< ANG_FRAC;
  localparam logic signed [CORDIC_W-1:0] Z_RND = CORDIC_W'(2 ** ZRND_SH) >>> 1;

  logic                       busy_r, busy_nxt, fin_r, fin_nxt, done_r, done_nxt;
  logic                       zero_r, zero_nxt;
  logic [ITER_W-1:0]          iter_r, iter_nxt;
  logic signed [CORDIC_W-1:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic signed [CORDIC_W-1:0] xe, ye, x0, y0, z0, dx, dy, zr;
  q_t                         res_r, res_nxt;

  always_comb begin
    busy_nxt = busy_r;
    fin_nxt  = fin_r;
    done_nxt = 1'b0;
    zero_nxt = zero_r;
    iter_nxt = iter_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    res_nxt  = res_r;
    xe = CORDIC_W'(x_in);
    ye = CORDIC_W'(y_in);
    x0 = xe;
    y0 = ye;
    z0 = '0;
    // Operands left of the y axis are first turned by a quarter turn.
    if (xe < 0) begin
      if (ye >= 0) begin
        x0 = ye;
        y0 = -xe;
        z0 = Z_QUARTER;
      end else begin
        x0 = -ye;
        y0 = xe;
        z0 = -Z_QUARTER;
      end
    end
    dx = x_r >>> iter_r;
    dy = y_r >>> iter_r;
    zr = (z_r + Z_RND) >>> ZRND_SH;
    if (start) begin
      x_nxt    = x0 <<< CORDIC_PRESCALE;
      y_nxt    = y0 <<< CORDIC_PRESCALE;
      z_nxt    = z0;
      zero_nxt = (x_in == '0) && (y_in == '0);
      iter_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!y_r[CORDIC_W-1]) begin
        x_nxt = x_r + dy;
        y_nxt = y_r - dx;
        z_nxt = z_r + atan_q24(5'(iter_r));
      end else begin
        x_nxt = x_r - dy;
        y_nxt = y_r + dx;
        z_nxt = z_r - atan_q24(5'(iter_r));
      end
      iter_nxt = iter_r + 1'b1;
      if (iter_r == ITER_W'(CORDIC_ITERS - 1)) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end else if (fin_r) begin
      fin_nxt  = 1'b0;
      done_nxt = 1'b1;
      res_nxt  = zero_r ? '0 : sat32(64'(zr));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      done_r <= done_nxt;
    end
    zero_r <= zero_nxt;
    iter_r <= iter_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    res_r  <= res_nxt;
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

>>> rtl/kalman_tilt_estimator.sv
// ----------------------------------------------------------------------------
// Kalman tilt estimator
// Two-state (angle, gyro bias) Kalman filter for pitch and roll of an IMU.
// ----------------------------------------------------------------------------
// Each accepted IMU sample whose timestamp lies at least min_period_ms past
// the last update runs one filter update and produces one transfer on the
// result channel holding pitch and roll in degrees, Q16.16. Samples that come
// too early are still accepted but produce no result. All arithmetic of an
// update goes through one bit-serial multiplier (ten products per axis), one
// bit-serial divider (one for the time step and two gains per axis) and one
// CORDIC unit (one rotation per cycle, once per axis), and a sequencer issues
// these operations one at a time. A new sample is taken whenever the sequencer
// is idle, even while the previous result still waits in the output
// register.
module kalman_tilt_estimator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  input  logic signed [15:0] in_accel_z,
  input  logic signed [15:0] in_gyro_x,
  input  logic signed [15:0] in_gyro_y,
  input  logic [31:0]        in_time_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_pitch_angle,
  output logic signed [31:0] out_roll_angle,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import kte_pkg::*;

  `include "kalman_tilt_estimator_defines.svh"

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_WAIT = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic   axis_r, axis_nxt;

  // Configuration registers.
  logic [9:0]  min_period_r;
  logic [15:0] angle_noise_r, bias_noise_r, measure_noise_r;

  // Sample and timing registers.
  logic [31:0]        last_r, last_nxt, el_r, el_nxt, elapsed;
  logic signed [15:0] ax_r, ay_r, az_r, gx_r, gy_r;
  logic               early, take;

  // Working values of the current update.
  q_t dt_r, dt_nxt, meas_r, meas_nxt, rate_r, rate_nxt;
  q_t inner_r, inner_nxt, y_r, y_nxt, s_r, s_nxt, k0_r, k0_nxt, k1_r, k1_nxt;
  q_t tmp_a_r, tmp_a_nxt, tmp_b_r, tmp_b_nxt;

  // Filter state: the axis being worked on sits in the current bank, the other
  // axis in the second bank; the banks swap when an axis is finished.
  q_t ang_c_r, ang_c_nxt, bias_c_r, bias_c_nxt, ang_o_r, ang_o_nxt, bias_o_r, bias_o_nxt;
  q_t p_c_r [4];
  q_t p_c_nxt [4];
  q_t p_o_r [4];
  q_t p_o_nxt [4];

  q_t   out_pitch_r, out_pitch_nxt, out_roll_r, out_roll_nxt;
  logic out_valid_r, out_valid_nxt;

  // Arithmetic units.
  logic                  mul_start, mul_done, div_start, div_done, cor_start, cor_done;
  q_t                    mul_a, mul_b, mul_res, div_res, cor_res;
  logic [DIV_NUM_W-1:0]  div_num;
  logic [DATA_W-1:0]     div_den;
  logic                  div_neg;
  logic signed [16:0]    cor_y, cor_x;
  logic                  unit_done;

  q_t qa, qb, rn, rate_in, m;
  logic signed [15:0] g_sel;

  kte_mul u_mul (
    .clk, .rst_n, .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .result(mul_res)
  );

  kte_div u_div (
    .clk, .rst_n, .start(div_start), .num(div_num), .den(div_den), .neg(div_neg),
    .done(div_done), .result(div_res)
  );

  kte_cordic u_cordic (
    .clk, .rst_n, .start(cor_start), .y_in(cor_y), .x_in(cor_x),
    .done(cor_done), .result(cor_res)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign elapsed   = in_time_ms - last_r;
  assign early     = (elapsed < 32'(min_period_r));
  assign take      = in_valid && in_ready;

  assign qa = noise_to_q(angle_noise_r);
  assign qb = noise_to_q(bias_noise_r);
  assign rn = noise_to_q(measure_noise_r);

  // Pitch pairs with the y gyro, roll with the x gyro.
  assign g_sel   = axis_r ? gx_r : gy_r;
  assign rate_in = sat32(64'(g_sel) <<< GYRO_SHIFT);
  assign cor_y   = axis_r ? 17'(ay_r) : -17'(ax_r);
  assign cor_x   = 17'(az_r);

  assign unit_done = mul_done || div_done || cor_done;
  assign m         = mul_res;

  // Operation launch: each step of the update program starts exactly one unit.
  always_comb begin
    mul_start = 1'b0;
    div_start = 1'b0;
    cor_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_num   = '0;
    div_den   = '0;
    div_neg   = 1'b0;
    if (state_r == S_RUN) begin
      unique case (op_r)
        OP_DT: begin
          div_start = 1'b1;
          div_num   = (DIV_NUM_W'(el_r) << FRAC_BITS) + DIV_NUM_W'(MS_PER_S / 2);
          div_den   = DATA_W'(MS_PER_S);
        end
        OP_ATAN: cor_start = 1'b1;
        OP_M1:   begin mul_start = 1'b1; mul_a = dt_r;  mul_b = rate_r;   end
        OP_M2:   begin mul_start = 1'b1; mul_a = dt_r;  mul_b = p_c_r[3]; end
        OP_M3:   begin mul_start = 1'b1; mul_a = dt_r;  mul_b = inner_r;  end
        OP_M4:   begin mul_start = 1'b1; mul_a = qb;    mul_b = dt_r;     end
        OP_D0: begin
          div_start = 1'b1;
          div_num   = DIV_NUM_W'(qabs(p_c_r[0])) << FRAC_BITS;
          div_den   = qabs(s_r);
          div_neg   = p_c_r[0][DATA_W-1] ^ s_r[DATA_W-1];
        end
        OP_D1: begin
          div_start = 1'b1;
          div_num   = DIV_NUM_W'(qabs(p_c_r[2])) << FRAC_BITS;
          div_den   = qabs(s_r);
          div_neg   = p_c_r[2][DATA_W-1] ^ s_r[DATA_W-1];
        end
        OP_M5:   begin mul_start = 1'b1; mul_a = k0_r;  mul_b = y_r;      end
        OP_M6:   begin mul_start = 1'b1; mul_a = k1_r;  mul_b = y_r;      end
        OP_M7:   begin mul_start = 1'b1; mul_a = k0_r;  mul_b = p_c_r[0]; end
        OP_M8:   begin mul_start = 1'b1; mul_a = k0_r;  mul_b = p_c_r[1]; end
        OP_M9:   begin mul_start = 1'b1; mul_a = k1_r;  mul_b = p_c_r[0]; end
        OP_M10:  begin mul_start = 1'b1; mul_a = k1_r;  mul_b = p_c_r[1]; end
        default: ;
      endcase
    end
  end

  // Sequencer and write-back of unit results.
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    axis_nxt      = axis_r;
    last_nxt      = last_r;
    el_nxt        = el_r;
    dt_nxt        = dt_r;
    meas_nxt      = meas_r;
    rate_nxt      = rate_r;
    inner_nxt     = inner_r;
    y_nxt         = y_r;
    s_nxt         = s_r;
    k0_nxt        = k0_r;
    k1_nxt        = k1_r;
    tmp_a_nxt     = tmp_a_r;
    tmp_b_nxt     = tmp_b_r;
    ang_c_nxt     = ang_c_r;
    bias_c_nxt    = bias_c_r;
    ang_o_nxt     = ang_o_r;
    bias_o_nxt    = bias_o_r;
    p_c_nxt       = p_c_r;
    p_o_nxt       = p_o_r;
    out_pitch_nxt = out_pitch_r;
    out_roll_nxt  = out_roll_r;
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      S_IDLE: begin
        if (take && !early) begin
          last_nxt  = in_time_ms;
          el_nxt    = elapsed;
          op_nxt    = OP_DT;
          axis_nxt  = 1'b0;
          state_nxt = S_RUN;
        end
      end
      S_RUN: state_nxt = S_WAIT;
      S_WAIT: begin
        if (unit_done) begin
          state_nxt = S_RUN;
          op_nxt    = op_t'(op_r + 4'd1);
          unique case (op_r)
            OP_DT: dt_nxt = div_res;
            OP_ATAN: begin
              meas_nxt = cor_res;
              rate_nxt = qsub(rate_in, bias_c_r);
            end
            OP_M1: ang_c_nxt = qadd(ang_c_r, m);
            OP_M2: begin
              tmp_a_nxt = m;
              inner_nxt = sat32(64'(m) - 64'(p_c_r[2]) - 64'(p_c_r[1]) + 64'(qa));
            end
            OP_M3: begin
              p_c_nxt[0] = qadd(p_c_r[0], m);
              p_c_nxt[1] = qsub(p_c_r[1], tmp_a_r);
              p_c_nxt[2] = qsub(p_c_r[2], tmp_a_r);
            end
            OP_M4: begin
              p_c_nxt[3] = qadd(p_c_r[3], m);
              y_nxt      = qsub(meas_r, ang_c_r);
              s_nxt      = qadd(p_c_r[0], rn);
            end
            OP_D0: k0_nxt = div_res;
            OP_D1: k1_nxt = div_res;
            OP_M5: ang_c_nxt  = qadd(ang_c_r, m);
            OP_M6: bias_c_nxt = qadd(bias_c_r, m);
            OP_M7: tmp_a_nxt = m;
            OP_M8: tmp_b_nxt = m;
            OP_M9: begin
              p_c_nxt[2] = qsub(p_c_r[2], m);
              p_c_nxt[0] = qsub(p_c_r[0], tmp_a_r);
            end
            OP_M10: begin
              p_c_nxt[3] = qsub(p_c_r[3], m);
              p_c_nxt[1] = qsub(p_c_r[1], tmp_b_r);
              // Axis finished: swap banks so the other axis becomes current.
              p_o_nxt    = p_c_nxt;
              p_c_nxt    = p_o_r;
              ang_o_nxt  = ang_c_r;
              ang_c_nxt  = ang_o_r;
              bias_o_nxt = bias_c_r;
              bias_c_nxt = bias_o_r;
              op_nxt     = OP_ATAN;
              axis_nxt   = 1'b1;
              if (axis_r) state_nxt = S_OUT;
            end
            default: ;
          endcase
        end
      end
      S_OUT: begin
        // After both swaps pitch is back in the current bank.
        if (!out_valid_r || out_ready) begin
          out_pitch_nxt = ang_c_r;
          out_roll_nxt  = ang_o_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      op_r            <= OP_DT;
      axis_r          <= 1'b0;
      out_valid_r     <= 1'b0;
      last_r          <= '0;
      ang_c_r         <= '0;
      bias_c_r        <= '0;
      ang_o_r         <= '0;
      bias_o_r        <= '0;
      p_c_r           <= '{default: '0};
      p_o_r           <= '{default: '0};
      min_period_r    <= 10'd10;
      angle_noise_r   <= 16'd66;
      bias_noise_r    <= 16'd197;
      measure_noise_r <= 16'd1966;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      axis_r      <= axis_nxt;
      out_valid_r <= out_valid_nxt;
      last_r      <= last_nxt;
      ang_c_r     <= ang_c_nxt;
      bias_c_r    <= bias_c_nxt;
      ang_o_r     <= ang_o_nxt;
      bias_o_r    <= bias_o_nxt;
      p_c_r       <= p_c_nxt;
      p_o_r       <= p_o_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_MIN_PERIOD:    min_period_r    <= cfg_data[9:0];
          CFG_ANGLE_NOISE:   angle_noise_r   <= cfg_data;
          CFG_BIAS_NOISE:    bias_noise_r    <= cfg_data;
          CFG_MEASURE_NOISE: measure_noise_r <= cfg_data;
          default: ;
        endcase
      end
    end
    if (take) begin
      ax_r <= in_accel_x;
      ay_r <= in_accel_y;
      az_r <= in_accel_z;
      gx_r <= in_gyro_x;
      gy_r <= in_gyro_y;
    end
    el_r        <= el_nxt;
    dt_r        <= dt_nxt;
    meas_r      <= meas_nxt;
    rate_r      <= rate_nxt;
    inner_r     <= inner_nxt;
    y_r         <= y_nxt;
    s_r         <= s_nxt;
    k0_r        <= k0_nxt;
    k1_r        <= k1_nxt;
    tmp_a_r     <= tmp_a_nxt;
    tmp_b_r     <= tmp_b_nxt;
    out_pitch_r <= out_pitch_nxt;
    out_roll_r  <= out_roll_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_pitch_angle = out_pitch_r;
  assign out_roll_angle  = out_roll_r;

  // Only one arithmetic unit is ever in flight.
  `KTE_ASSERT_IMP(a_single_unit, clk, rst_n, 1'b1, $onehot0({mul_done, div_done, cor_done}))
  // A unit only finishes while the sequencer waits for it.
  `KTE_ASSERT_IMP(a_done_in_wait, clk, rst_n, unit_done, state_r == S_WAIT)
  // An early sample leaves the timestamp and the sequencer untouched.
  `KTE_ASSERT_NXT(a_early_drop, clk, rst_n, take && early, state_r == S_IDLE && $stable(last_r))

endmodule
